/* rtl/core/dsc_pkg.sv */
// dsc_pkg: shared types and constants of the debug step controller
// event codes, run state, step mode, pause reasons and the configuration bundle
// no dependencies
`timescale 1ns / 1ps

package dsc_pkg;

    // debug event codes carried in the request kind field
    typedef enum logic [3:0] {
        OP_REQ_PAUSE    = 4'd0,
        OP_PAUSE        = 4'd1,
        OP_RESUME       = 4'd2,
        OP_TERMINATE    = 4'd3,
        OP_INTO         = 4'd4,
        OP_OVER         = 4'd5,
        OP_OUT          = 4'd6,
        OP_CONTINUE     = 4'd7,
        OP_LINE         = 4'd8,
        OP_ASYNC_ENTER  = 4'd9,
        OP_AWAIT        = 4'd10,
        OP_ASYNC_RESUME = 4'd11,
        OP_EXCEPTION    = 4'd12,
        OP_WD_RESET     = 4'd13,
        OP_TICK         = 4'd14,
        OP_WD_CHECK     = 4'd15
    } op_t;

    typedef enum logic [1:0] {
        RS_RUNNING    = 2'd0,
        RS_PAUSED     = 2'd1,
        RS_STEPPING   = 2'd2,
        RS_TERMINATED = 2'd3
    } run_state_t;

    typedef enum logic [2:0] {
        MD_NONE = 3'd0,
        MD_INTO = 3'd1,
        MD_OVER = 3'd2,
        MD_OUT  = 3'd3,
        MD_CONT = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        RSN_NONE      = 3'd0,
        RSN_REQUESTED = 3'd1,
        RSN_INTO_DONE = 3'd2,
        RSN_OVER_DONE = 3'd3,
        RSN_OUT_DONE  = 3'd4,
        RSN_EXCEPTION = 3'd5,
        RSN_TIMEOUT   = 3'd6,
        RSN_EXTERNAL  = 3'd7
    } reason_t;

    // classified control part of one request
    typedef struct packed {
        op_t  op;
        logic caught;
    } cmd_ctrl_t;

    localparam int CTRL_BITS = $bits(cmd_ctrl_t);

    // configuration seen by the execution side
    typedef struct packed {
        logic        pause_on_caught;
        logic        pause_on_uncaught;
        logic        async_aware;
        logic        watchdog_enable;
        logic [31:0] watchdog_limit;
    } cfg_t;

    // one result
    typedef struct packed {
        mode_t      active_mode;
        run_state_t run_state;
        reason_t    pause_reason;
        logic       should_pause;
    } result_t;

    localparam logic [31:0] WD_LIMIT_RESET = 32'd30000;
    localparam logic [31:0] TICK_MAX       = 32'hFFFF_FFFF;

endpackage

/* rtl/core/dsc_front.sv */
// dsc_front: input side of the debug step controller
// accepts stream requests, classifies the event and packs it for the queue
// depends on dsc_pkg
`timescale 1ns / 1ps

module dsc_front
    import dsc_pkg::*;
#(
    parameter int DEPTH_BITS   = 16,
    parameter int FILE_ID_BITS = 16,
    parameter int WORD_BITS    = CTRL_BITS + DEPTH_BITS + FILE_ID_BITS + 32
)
(
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [15:0] frame_depth, [31:16] file_id, [63:32] line_number, [64] is_caught
    input  logic [71:0]          s_axis_tdata,
    // [3:0] opcode
    input  logic [3:0]           s_axis_tuser,
    input  logic                 q_full,
    output logic                 q_push,
    output logic [WORD_BITS-1:0] q_word
);

    logic [31:0]             depth_ext;
    logic [31:0]             file_ext;
    logic [DEPTH_BITS-1:0]   depth;
    logic [FILE_ID_BITS-1:0] file;
    cmd_ctrl_t               ctrl;

    // take a request whenever the queue has room
    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;

    // keep depth and file id in their configured widths
    assign depth_ext = {16'd0, s_axis_tdata[15:0]};
    assign file_ext  = {16'd0, s_axis_tdata[31:16]};
    assign depth     = depth_ext[DEPTH_BITS-1:0];
    assign file      = file_ext[FILE_ID_BITS-1:0];

    // classify the event
    always_comb
    begin
        ctrl.op     = op_t'(s_axis_tuser);
        ctrl.caught = s_axis_tdata[64];
    end

    // queue word from the top: line, file, depth, control
    assign q_word = {s_axis_tdata[63:32], file, depth, ctrl};

endmodule

/* rtl/core/dsc_fifo.sv */
// dsc_fifo: two-entry request queue between front and back
// register storage, push and pop in the same cycle allowed
// depends on dsc_pkg only for the shared import convention
`timescale 1ns / 1ps

module dsc_fifo
    import dsc_pkg::*;
#(
    parameter int WORD_BITS = 69
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic [WORD_BITS-1:0] push_word,
    output logic                 full,
    input  logic                 pop,
    output logic                 head_valid,
    output logic [WORD_BITS-1:0] head_word
);

    logic [WORD_BITS-1:0] mem_reg [2];
    logic                 wr_ptr_reg;
    logic                 wr_ptr_next;
    logic                 rd_ptr_reg;
    logic                 rd_ptr_next;
    logic [1:0]           count_reg;
    logic [1:0]           count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_word  = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

    // queue never overflows or underflows
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");

endmodule

/* rtl/core/dsc_back.sv */
// dsc_back: execution side of the debug step controller
// runs each queued event against the run and step state, registers the result
// depends on dsc_pkg
`timescale 1ns / 1ps

module dsc_back
    import dsc_pkg::*;
#(
    parameter int DEPTH_BITS   = 16,
    parameter int FILE_ID_BITS = 16,
    parameter int WORD_BITS    = CTRL_BITS + DEPTH_BITS + FILE_ID_BITS + 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfg_t                 cfg,
    input  logic                 head_valid,
    input  logic [WORD_BITS-1:0] head_word,
    output logic                 pop,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [0] should_pause, [3:1] pause_reason, [5:4] run_state, [8:6] active_mode
    output logic [15:0]          m_axis_tdata
);

    cmd_ctrl_t               ctrl;
    logic [DEPTH_BITS-1:0]   depth;
    logic [FILE_ID_BITS-1:0] file;
    logic [31:0]             line;
    logic                    moved;
    logic                    exc_pause;
    reason_t                 reason;

    run_state_t              run_reg,         run_next;
    mode_t                   mode_reg,        mode_next;
    logic                    pend_reg,        pend_next;
    logic [DEPTH_BITS-1:0]   start_depth_reg, start_depth_next;
    logic [FILE_ID_BITS-1:0] start_file_reg,  start_file_next;
    logic [31:0]             start_line_reg,  start_line_next;
    logic                    in_async_reg,    in_async_next;
    logic [DEPTH_BITS-1:0]   async_depth_reg, async_depth_next;
    logic                    await_reg,       await_next;
    logic [31:0]             ticks_reg,       ticks_next;
    logic                    out_valid_reg,   out_valid_next;
    result_t                 res_reg,         res_next;

    // unpack the queue word
    assign ctrl  = cmd_ctrl_t'(head_word[CTRL_BITS-1:0]);
    assign depth = head_word[CTRL_BITS +: DEPTH_BITS];
    assign file  = head_word[CTRL_BITS + DEPTH_BITS +: FILE_ID_BITS];
    assign line  = head_word[CTRL_BITS + DEPTH_BITS + FILE_ID_BITS +: 32];

    // take the next event when the output register is free or drains now
    assign pop = head_valid && (!out_valid_reg || m_axis_tready);

    assign moved     = (file != start_file_reg) || (line != start_line_reg);
    assign exc_pause = ctrl.caught ? cfg.pause_on_caught : cfg.pause_on_uncaught;

    // event execution
    always_comb
    begin
        run_next         = run_reg;
        mode_next        = mode_reg;
        pend_next        = pend_reg;
        start_depth_next = start_depth_reg;
        start_file_next  = start_file_reg;
        start_line_next  = start_line_reg;
        in_async_next    = in_async_reg;
        async_depth_next = async_depth_reg;
        await_next       = await_reg;
        ticks_next       = ticks_reg;
        reason           = RSN_NONE;

        if (pop)
        begin
            unique case (ctrl.op) inside
                OP_REQ_PAUSE:
                begin
                    pend_next = 1'b1;
                end
                OP_PAUSE:
                begin
                    reason = RSN_EXTERNAL;
                end
                OP_RESUME:
                begin
                    if (run_reg != RS_TERMINATED)
                    begin
                        run_next         = RS_RUNNING;
                        pend_next        = 1'b0;
                        mode_next        = MD_NONE;
                        start_depth_next = '0;
                        start_file_next  = '0;
                        start_line_next  = '0;
                    end
                end
                OP_TERMINATE:
                begin
                    run_next         = RS_TERMINATED;
                    mode_next        = MD_NONE;
                    start_depth_next = '0;
                    start_file_next  = '0;
                    start_line_next  = '0;
                end
                OP_INTO, OP_OVER, OP_OUT:
                begin
                    case (ctrl.op)
                        OP_INTO: mode_next = MD_INTO;
                        OP_OVER: mode_next = MD_OVER;
                        default: mode_next = MD_OUT;
                    endcase
                    start_depth_next = depth;
                    start_file_next  = file;
                    start_line_next  = line;
                    run_next         = RS_STEPPING;
                    pend_next        = 1'b0;
                end
                OP_CONTINUE:
                begin
                    mode_next = MD_CONT;
                    run_next  = RS_RUNNING;
                    pend_next = 1'b0;
                end
                OP_LINE:
                begin
                    if (pend_reg)
                    begin
                        pend_next = 1'b0;
                    end
                    else if (mode_reg == MD_INTO && moved)
                    begin
                        reason = RSN_INTO_DONE;
                    end
                    else if (mode_reg == MD_OVER && depth <= start_depth_reg && moved)
                    begin
                        reason = RSN_OVER_DONE;
                    end
                    else if (mode_reg == MD_OUT && depth < start_depth_reg)
                    begin
                        reason = RSN_OUT_DONE;
                    end
                end
                OP_ASYNC_ENTER:
                begin
                    if (cfg.async_aware && mode_reg == MD_OVER)
                    begin
                        in_async_next    = 1'b1;
                        async_depth_next = depth;
                    end
                end
                OP_AWAIT:
                begin
                    if (cfg.async_aware && in_async_reg && mode_reg == MD_OVER
                        && depth <= async_depth_reg)
                    begin
                        await_next = 1'b1;
                    end
                end
                OP_ASYNC_RESUME:
                begin
                    if (await_reg && mode_reg == MD_OVER)
                    begin
                        await_next       = 1'b0;
                        in_async_next    = 1'b0;
                        start_depth_next = depth;
                        start_file_next  = file;
                        start_line_next  = line;
                    end
                end
                OP_EXCEPTION:
                begin
                    if (exc_pause)
                    begin
                        reason = RSN_EXCEPTION;
                    end
                end
                OP_WD_RESET:
                begin
                    ticks_next = '0;
                end
                OP_TICK:
                begin
                    if (ticks_reg != TICK_MAX)
                    begin
                        ticks_next = ticks_reg + 32'd1;
                    end
                end
                OP_WD_CHECK:
                begin
                    if (cfg.watchdog_enable && ticks_reg >= cfg.watchdog_limit)
                    begin
                        reason = RSN_TIMEOUT;
                    end
                end
                default:
                begin
                    reason = RSN_NONE;
                end
            endcase

            // a pause clears the step, async tracking stays
            if (reason != RSN_NONE && reason != RSN_REQUESTED)
            begin
                run_next         = RS_PAUSED;
                mode_next        = MD_NONE;
                start_depth_next = '0;
                start_file_next  = '0;
                start_line_next  = '0;
            end
            // a served pause request reports without touching run state or step mode
            if (ctrl.op == OP_LINE && pend_reg)
            begin
                reason = RSN_REQUESTED;
            end
        end
    end

    // result register
    always_comb
    begin
        res_next                = res_reg;
        out_valid_next          = out_valid_reg;
        if (pop)
        begin
            res_next.should_pause = (reason != RSN_NONE);
            res_next.pause_reason = reason;
            res_next.run_state    = run_next;
            res_next.active_mode  = mode_next;
            out_valid_next        = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg         <= RS_RUNNING;
            mode_reg        <= MD_NONE;
            pend_reg        <= 1'b0;
            start_depth_reg <= '0;
            start_file_reg  <= '0;
            start_line_reg  <= '0;
            in_async_reg    <= 1'b0;
            async_depth_reg <= '0;
            await_reg       <= 1'b0;
            ticks_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            run_reg         <= run_next;
            mode_reg        <= mode_next;
            pend_reg        <= pend_next;
            start_depth_reg <= start_depth_next;
            start_file_reg  <= start_file_next;
            start_line_reg  <= start_line_next;
            in_async_reg    <= in_async_next;
            async_depth_reg <= async_depth_next;
            await_reg       <= await_next;
            ticks_reg       <= ticks_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, res_reg.active_mode, res_reg.run_state,
                            res_reg.pause_reason, res_reg.should_pause};

    // pause flag and reason agree
    a_flag_reason: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (res_reg.should_pause == (res_reg.pause_reason != RSN_NONE)))
        else $error("pause flag and reason disagree");

    // a real pause leaves the block paused with no step mode
    a_pause_state: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.should_pause && res_reg.pause_reason != RSN_REQUESTED)
        |-> (res_reg.run_state == RS_PAUSED && res_reg.active_mode == MD_NONE))
        else $error("pause without paused state");

    // every executed event shows up as a result
    a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> out_valid_reg)
        else $error("executed event lost its result");

endmodule

/* rtl/core/debug_step_controller.sv */
// debug_step_controller: top level of the debug step controller
// holds the configuration registers, ties front, queue and back together
// depends on dsc_pkg, dsc_front, dsc_fifo, dsc_back
`timescale 1ns / 1ps

// One debug event is taken per request on the s_axis side (opcode in tuser,
// depth, file id, line and caught flag in tdata) and exactly one result comes
// out on m_axis: whether execution pauses, the reason, and the run state and
// step mode after the event. The block takes one event per clock cycle while
// the queue has room and m_axis is not stalled; an accepted request is written
// into the two-entry queue and then executed into the result register, from
// which it is presented on m_axis. The combinational state update sets the rate.
// The configuration registers sit on an APB port at byte addresses 0, 4, 8, 12
// and 16; the user must write them only while no event is in flight, and the
// block itself does not enforce this.

module debug_step_controller
    import dsc_pkg::*;
#(
    parameter int DEPTH_BITS   = 16,
    parameter int FILE_ID_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // request side
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] frame_depth, [31:16] file_id, [63:32] line_number, [64] is_caught
    input  logic [71:0] s_axis_tdata,
    // [3:0] opcode
    input  logic [3:0]  s_axis_tuser,
    // result side
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] should_pause, [3:1] pause_reason, [5:4] run_state, [8:6] active_mode
    output logic [15:0] m_axis_tdata,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int WORD_BITS = CTRL_BITS + DEPTH_BITS + FILE_ID_BITS + 32;

    localparam logic [2:0] REG_PAUSE_ON_CAUGHT   = 3'd0;
    localparam logic [2:0] REG_PAUSE_ON_UNCAUGHT = 3'd1;
    localparam logic [2:0] REG_ASYNC_AWARE       = 3'd2;
    localparam logic [2:0] REG_WATCHDOG_ENABLE   = 3'd3;
    localparam logic [2:0] REG_WATCHDOG_LIMIT    = 3'd4;

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic                 cfg_write;
    logic [2:0]           reg_index;
    logic                 q_full;
    logic                 q_push;
    logic [WORD_BITS-1:0] q_word;
    logic                 q_pop;
    logic                 q_head_valid;
    logic [WORD_BITS-1:0] q_head_word;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (reg_index)
                REG_PAUSE_ON_CAUGHT:   cfg_next.pause_on_caught   = pwdata[0];
                REG_PAUSE_ON_UNCAUGHT: cfg_next.pause_on_uncaught = pwdata[0];
                REG_ASYNC_AWARE:       cfg_next.async_aware       = pwdata[0];
                REG_WATCHDOG_ENABLE:   cfg_next.watchdog_enable   = pwdata[0];
                REG_WATCHDOG_LIMIT:    cfg_next.watchdog_limit    = pwdata;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    // register read mux
    always_comb
    begin
        unique case (reg_index)
            REG_PAUSE_ON_CAUGHT:   prdata = {31'd0, cfg_reg.pause_on_caught};
            REG_PAUSE_ON_UNCAUGHT: prdata = {31'd0, cfg_reg.pause_on_uncaught};
            REG_ASYNC_AWARE:       prdata = {31'd0, cfg_reg.async_aware};
            REG_WATCHDOG_ENABLE:   prdata = {31'd0, cfg_reg.watchdog_enable};
            REG_WATCHDOG_LIMIT:    prdata = cfg_reg.watchdog_limit;
            default:               prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pause_on_caught   <= 1'b0;
            cfg_reg.pause_on_uncaught <= 1'b1;
            cfg_reg.async_aware       <= 1'b1;
            cfg_reg.watchdog_enable   <= 1'b0;
            cfg_reg.watchdog_limit    <= WD_LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // request intake and classification
    dsc_front #(
        .DEPTH_BITS   (DEPTH_BITS),
        .FILE_ID_BITS (FILE_ID_BITS),
        .WORD_BITS    (WORD_BITS)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_word        (q_word)
    );

    // request queue
    dsc_fifo #(
        .WORD_BITS (WORD_BITS)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_word  (q_word),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_word  (q_head_word)
    );

    // event execution and result register
    dsc_back #(
        .DEPTH_BITS   (DEPTH_BITS),
        .FILE_ID_BITS (FILE_ID_BITS),
        .WORD_BITS    (WORD_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .head_valid    (q_head_valid),
        .head_word     (q_head_word),
        .pop           (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

/* tb/testbench.sv */
// testbench: self-checking bench for the debug step controller
// holds a pause tracker class that predicts each result, plus stream and apb drivers
// depends on dsc_pkg and debug_step_controller
`timescale 1ns / 1ps

module testbench;
    import dsc_pkg::*;

    // register indexes, byte address is four times the index
    localparam int REG_PAUSE_CAUGHT   = 0;
    localparam int REG_PAUSE_UNCAUGHT = 1;
    localparam int REG_ASYNC_AWARE    = 2;
    localparam int REG_WD_ENABLE      = 3;
    localparam int REG_WD_LIMIT       = 4;

    localparam int PHASE_ITEMS = 170;
    localparam int HOLD_CYCLES = 80;

    // predicts run state, step mode and pause decision for every event
    class pause_tracker;
        cfg_t       cfg;
        run_state_t cur_state;
        mode_t      cur_mode;
        logic       pause_wanted;
        logic [15:0] anchor_depth;
        logic [15:0] anchor_file;
        logic [31:0] anchor_line;
        logic       async_live;
        logic [15:0] async_floor;
        logic       await_armed;
        logic [31:0] tick_count;
        result_t    pending_outcomes[$];
        int         mismatches;
        int         accepted;
        int         checked;
        int         pauses;

        function new();
            cfg.pause_on_caught   = 1'b0;
            cfg.pause_on_uncaught = 1'b1;
            cfg.async_aware       = 1'b1;
            cfg.watchdog_enable   = 1'b0;
            cfg.watchdog_limit    = WD_LIMIT_RESET;
            cur_state    = RS_RUNNING;
            cur_mode     = MD_NONE;
            pause_wanted = 1'b0;
            anchor_depth = '0;
            anchor_file  = '0;
            anchor_line  = '0;
            async_live   = 1'b0;
            async_floor  = '0;
            await_armed  = 1'b0;
            tick_count   = '0;
            mismatches   = 0;
            accepted     = 0;
            checked      = 0;
            pauses       = 0;
        endfunction

        function void set_register(int idx, logic [31:0] value);
            case (idx)
                REG_PAUSE_CAUGHT:   cfg.pause_on_caught   = value[0];
                REG_PAUSE_UNCAUGHT: cfg.pause_on_uncaught = value[0];
                REG_ASYNC_AWARE:    cfg.async_aware       = value[0];
                REG_WD_ENABLE:      cfg.watchdog_enable   = value[0];
                REG_WD_LIMIT:       cfg.watchdog_limit    = value;
                default: ;
            endcase
        endfunction

        function void drop_step();
            cur_mode     = MD_NONE;
            anchor_depth = '0;
            anchor_file  = '0;
            anchor_line  = '0;
        endfunction

        function void start_step(mode_t m, logic [15:0] depth, logic [15:0] file,
                                 logic [31:0] line);
            cur_mode     = m;
            anchor_depth = depth;
            anchor_file  = file;
            anchor_line  = line;
            cur_state    = RS_STEPPING;
            pause_wanted = 1'b0;
        endfunction

        // note one accepted request and queue the result it must produce
        function void note_event(op_t op, logic [15:0] depth, logic [15:0] file,
                                 logic [31:0] line, logic caught);
            reason_t why;
            logic    moved;
            logic    enabled;
            result_t res;
            why = RSN_NONE;
            accepted++;
            case (op)
                OP_REQ_PAUSE: pause_wanted = 1'b1;
                OP_PAUSE: why = RSN_EXTERNAL;
                OP_RESUME:
                    if (cur_state != RS_TERMINATED)
                    begin
                        cur_state    = RS_RUNNING;
                        pause_wanted = 1'b0;
                        drop_step();
                    end
                OP_TERMINATE:
                begin
                    cur_state = RS_TERMINATED;
                    drop_step();
                end
                OP_INTO: start_step(MD_INTO, depth, file, line);
                OP_OVER: start_step(MD_OVER, depth, file, line);
                OP_OUT:  start_step(MD_OUT, depth, file, line);
                OP_CONTINUE:
                begin
                    cur_mode     = MD_CONT;
                    cur_state    = RS_RUNNING;
                    pause_wanted = 1'b0;
                end
                OP_LINE:
                    if (pause_wanted)
                    begin
                        // served request reports a pause but keeps state and mode
                        pause_wanted = 1'b0;
                        res.should_pause = 1'b1;
                        why = RSN_REQUESTED;
                    end
                    else
                    begin
                        moved = (file != anchor_file) || (line != anchor_line);
                        if (cur_mode == MD_INTO && moved)
                            why = RSN_INTO_DONE;
                        else if (cur_mode == MD_OVER && depth <= anchor_depth && moved)
                            why = RSN_OVER_DONE;
                        else if (cur_mode == MD_OUT && depth < anchor_depth)
                            why = RSN_OUT_DONE;
                    end
                OP_ASYNC_ENTER:
                    if (cfg.async_aware && cur_mode == MD_OVER)
                    begin
                        async_live  = 1'b1;
                        async_floor = depth;
                    end
                OP_AWAIT:
                    if (cfg.async_aware && async_live && cur_mode == MD_OVER
                        && depth <= async_floor)
                        await_armed = 1'b1;
                OP_ASYNC_RESUME:
                    if (await_armed && cur_mode == MD_OVER)
                    begin
                        await_armed  = 1'b0;
                        async_live   = 1'b0;
                        anchor_depth = depth;
                        anchor_file  = file;
                        anchor_line  = line;
                    end
                OP_EXCEPTION:
                begin
                    enabled = caught ? cfg.pause_on_caught : cfg.pause_on_uncaught;
                    if (enabled)
                        why = RSN_EXCEPTION;
                end
                OP_WD_RESET: tick_count = '0;
                OP_TICK:
                    if (tick_count != TICK_MAX)
                        tick_count = tick_count + 32'd1;
                default:
                    if (cfg.watchdog_enable && tick_count >= cfg.watchdog_limit)
                        why = RSN_TIMEOUT;
            endcase

            // every pause except a served request parks the machine
            if (why != RSN_NONE && why != RSN_REQUESTED)
            begin
                cur_state = RS_PAUSED;
                drop_step();
            end
            if (why != RSN_NONE)
                pauses++;
            res.should_pause = (why != RSN_NONE);
            res.pause_reason = why;
            res.run_state    = cur_state;
            res.active_mode  = cur_mode;
            pending_outcomes.push_back(res);
        endfunction

        // compare one delivered result with the oldest prediction
        function void check_outcome(logic [15:0] data);
            result_t want;
            if (pending_outcomes.size() == 0)
            begin
                $error("result %h arrived with nothing expected", data);
                mismatches++;
                return;
            end
            want = pending_outcomes.pop_front();
            checked++;
            if (data[0] !== want.should_pause)
            begin
                $error("should_pause: expected %0d, actual %0d", want.should_pause, data[0]);
                mismatches++;
            end
            if (data[3:1] !== want.pause_reason)
            begin
                $error("pause_reason: expected %0d, actual %0d", want.pause_reason, data[3:1]);
                mismatches++;
            end
            if (data[5:4] !== want.run_state)
            begin
                $error("run_state: expected %0d, actual %0d", want.run_state, data[5:4]);
                mismatches++;
            end
            if (data[8:6] !== want.active_mode)
            begin
                $error("active_mode: expected %0d, actual %0d", want.active_mode, data[8:6]);
                mismatches++;
            end
            if (data[15:9] !== 7'd0)
            begin
                $error("padding: expected 0, actual %0h", data[15:9]);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return pending_outcomes.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic [3:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    pause_tracker tracker;
    bit  idle_on;
    bit  hold_request;
    int  settings_used;

    debug_step_controller dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watch both handshakes at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            tracker.note_event(op_t'(s_axis_tuser), s_axis_tdata[15:0],
                               s_axis_tdata[31:16], s_axis_tdata[63:32], s_axis_tdata[64]);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_outcome(m_axis_tdata);
    end

    // result side backpressure, including one long hold-off
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request  = 1'b0;
                m_axis_tready = 1'b1;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
                m_axis_tready = 1'b1;
            end
            else
                m_axis_tready = 1'b1;
        end
    end

    // offer one request and hold it until taken
    task automatic send_event(input op_t op, input logic [15:0] depth,
                              input logic [15:0] file, input logic [31:0] line,
                              input logic caught);
        if (idle_on && $urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 12)) @(negedge clk) s_axis_tvalid = 1'b0;
        @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = {7'd0, caught, line, file, depth};
        do @(posedge clk); while (!s_axis_tready);
    endtask

    // stop offering and wait for every result to come back
    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input int idx, input logic [31:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = 5'(4 * idx);
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        tracker.set_register(idx, value);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apply_settings(input bit caught_on, input bit uncaught_on,
                                  input bit async_on, input bit wd_on,
                                  input logic [31:0] limit);
        write_register(REG_PAUSE_CAUGHT, {31'd0, caught_on});
        write_register(REG_PAUSE_UNCAUGHT, {31'd0, uncaught_on});
        write_register(REG_ASYNC_AWARE, {31'd0, async_on});
        write_register(REG_WD_ENABLE, {31'd0, wd_on});
        write_register(REG_WD_LIMIT, limit);
        settings_used++;
    endtask

    // small values mostly so steps actually complete, full range now and then
    function automatic logic [15:0] pick_depth();
        return ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
    endfunction

    function automatic logic [15:0] pick_file();
        return ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2));
    endfunction

    function automatic logic [31:0] pick_line();
        return ($urandom_range(0, 7) == 0) ? $urandom : 32'($urandom_range(0, 7));
    endfunction

    function automatic logic [15:0] nudge(input logic [15:0] d);
        return 16'(d + 16'($urandom_range(0, 2)) - 16'd1);
    endfunction

    task automatic send_noise();
        send_event(op_t'($urandom_range(0, 15)), pick_depth(), pick_file(), pick_line(),
                   1'($urandom_range(0, 1)));
    endtask

    // one random sequence: a step, an async step-over, a watchdog run or noise
    task automatic run_scenario();
        int          kind;
        int          n;
        op_t         step_op;
        logic [15:0] d;
        logic [15:0] f;
        logic [31:0] l;
        kind = $urandom_range(0, 9);
        d = pick_depth();
        f = pick_file();
        l = pick_line();
        if (kind <= 3)
        begin
            case ($urandom_range(0, 2))
                0:       step_op = OP_INTO;
                1:       step_op = OP_OVER;
                default: step_op = OP_OUT;
            endcase
            send_event(step_op, d, f, l, 1'b0);
            n = $urandom_range(1, 6);
            repeat (n)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_noise();
                send_event(OP_LINE, nudge(d),
                           ($urandom_range(0, 3) == 0) ? pick_file() : f,
                           ($urandom_range(0, 1) == 0) ? l : 32'(l + 1), 1'b0);
            end
        end
        else if (kind <= 5)
        begin
            send_event(OP_OVER, d, f, l, 1'b0);
            if ($urandom_range(0, 5) != 0)
                send_event(OP_ASYNC_ENTER, 16'(d + 16'($urandom_range(0, 1))), f, l, 1'b0);
            if ($urandom_range(0, 5) != 0)
                send_event(OP_AWAIT, nudge(d), f, l, 1'b0);
            d = pick_depth();
            f = pick_file();
            l = pick_line();
            send_event(OP_ASYNC_RESUME, d, f, l, 1'b0);
            n = $urandom_range(1, 4);
            repeat (n)
                send_event(OP_LINE, nudge(d), f,
                           ($urandom_range(0, 1) == 0) ? l : 32'(l + 1), 1'b0);
        end
        else if (kind == 6)
        begin
            send_event(OP_WD_RESET, d, f, l, 1'b0);
            n = $urandom_range(0, 24);
            repeat (n)
            begin
                send_event(OP_TICK, pick_depth(), pick_file(), pick_line(), 1'b0);
                if ($urandom_range(0, 5) == 0)
                    send_event(OP_WD_CHECK, d, f, l, 1'b0);
            end
            send_event(OP_WD_CHECK, d, f, l, 1'b0);
        end
        else
        begin
            n = $urandom_range(1, 4);
            repeat (n)
                send_noise();
        end
    endtask

    // main sequence
    initial
    begin
        int  phase;
        int  base;
        bit  hold_done;
        bit  pause_done;
        tracker       = new();
        idle_on       = 1'b1;
        hold_request  = 1'b0;
        hold_done     = 1'b0;
        pause_done    = 1'b0;
        settings_used = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_REQ_PAUSE;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part under the reset settings
        send_event(OP_LINE, 16'd0, 16'd0, 32'd0, 1'b0);
        send_event(OP_REQ_PAUSE, 16'd0, 16'd0, 32'd0, 1'b0);
        send_event(OP_LINE, 16'd3, 16'd1, 32'd5, 1'b0);
        send_event(OP_INTO, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
        send_event(OP_LINE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
        send_event(OP_LINE, 16'hFFFF, 16'd0, 32'hFFFF_FFFF, 1'b0);
        send_event(OP_OVER, 16'd5, 16'd1, 32'd10, 1'b0);
        send_event(OP_LINE, 16'd6, 16'd1, 32'd11, 1'b0);
        send_event(OP_LINE, 16'd5, 16'd1, 32'd11, 1'b0);
        send_event(OP_OUT, 16'd3, 16'd1, 32'd12, 1'b0);
        send_event(OP_LINE, 16'd3, 16'd1, 32'd13, 1'b0);
        send_event(OP_LINE, 16'd2, 16'd1, 32'd14, 1'b0);
        send_event(OP_CONTINUE, 16'd2, 16'd1, 32'd14, 1'b0);
        send_event(OP_EXCEPTION, 16'd2, 16'd1, 32'd14, 1'b1);
        send_event(OP_EXCEPTION, 16'd2, 16'd1, 32'd14, 1'b0);
        send_event(OP_OVER, 16'd4, 16'd2, 32'd20, 1'b0);
        send_event(OP_ASYNC_ENTER, 16'd4, 16'd2, 32'd21, 1'b0);
        send_event(OP_AWAIT, 16'd4, 16'd2, 32'd22, 1'b0);
        send_event(OP_ASYNC_RESUME, 16'd9, 16'd3, 32'd40, 1'b0);
        send_event(OP_LINE, 16'd9, 16'd3, 32'd41, 1'b0);
        send_event(OP_PAUSE, 16'd0, 16'd0, 32'd0, 1'b0);
        send_event(OP_RESUME, 16'd0, 16'd0, 32'd0, 1'b0);
        send_event(OP_TERMINATE, 16'd0, 16'd0, 32'd0, 1'b0);
        send_event(OP_RESUME, 16'd0, 16'd0, 32'd0, 1'b0);
        send_event(OP_INTO, 16'd1, 16'd1, 32'd1, 1'b0);
        send_event(OP_WD_RESET, 16'd0, 16'd0, 32'd0, 1'b0);
        send_event(OP_TICK, 16'd0, 16'd0, 32'd0, 1'b0);
        send_event(OP_WD_CHECK, 16'd0, 16'd0, 32'd0, 1'b0);
        drain_results();

        // random part, one register setting per phase, no idling in the last one
        for (phase = 0; phase < 6; phase++)
        begin
            idle_on = (phase < 5);
            case (phase)
                0: apply_settings(1'b0, 1'b1, 1'b1, 1'b0, WD_LIMIT_RESET);
                1: apply_settings(1'b1, 1'b1, 1'b1, 1'b1, 32'd0);
                2: apply_settings(1'b0, 1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF);
                3: apply_settings(1'b1, 1'b0, 1'b1, 1'b1, 32'($urandom_range(1, 12)));
                4: apply_settings(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  32'($urandom_range(0, 20)));
                default: apply_settings(1'b1, 1'b1, 1'b0, 1'b1, 32'd3);
            endcase
            base = tracker.accepted;
            while (tracker.accepted - base < PHASE_ITEMS)
            begin
                if (phase == 2 && !hold_done && tracker.accepted - base > 60)
                begin
                    hold_request = 1'b1;
                    hold_done    = 1'b1;
                end
                if (phase == 3 && !pause_done && tracker.accepted - base > 80)
                begin
                    drain_results();
                    pause_done = 1'b1;
                end
                run_scenario();
            end
            drain_results();
        end

        repeat (10) @(posedge clk);
        $display("ran %0d events through %0d register settings", tracker.accepted,
                 settings_used);
        $display("checked %0d results, %0d of them pauses", tracker.checked, tracker.pauses);
        if (tracker.mismatches == 0 && tracker.outstanding() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // hard limit on the run
    initial
    begin
        #3_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
